[design/bor_pkg.sv]
// ----------------------------------------------------------------------------
// bor_pkg: shared definitions for the box overlap ratio block
// Default widths for the coordinate fields and for the fraction of the
// fixed-point ratio, used by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package bor_pkg;

    // Width of one box coordinate, width or height.
    localparam int BOR_COORD_BITS = 16;

    // Number of fraction bits of the ratio; 1 << BOR_FRAC_BITS means 1.0.
    localparam int BOR_FRAC_BITS = 16;

endpackage : bor_pkg

[design/bor_if.sv]
// ----------------------------------------------------------------------------
// bor_in_if / bor_out_if: valid/ready channels of the box overlap ratio block
// The input channel carries one box pair and the mode bit per beat; the
// output channel carries the ratio, the overlap area and the zero flag.
// ----------------------------------------------------------------------------
interface bor_in_if
    import bor_pkg::*;
#(
    parameter int COORD_BITS = BOR_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] a_x;
    logic [COORD_BITS-1:0] a_y;
    logic [COORD_BITS-1:0] a_w;
    logic [COORD_BITS-1:0] a_h;
    logic [COORD_BITS-1:0] b_x;
    logic [COORD_BITS-1:0] b_y;
    logic [COORD_BITS-1:0] b_w;
    logic [COORD_BITS-1:0] b_h;

    modport source (
        output valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
        input  ready
    );

    modport sink (
        input  valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
        output ready
    );
endinterface : bor_in_if

interface bor_out_if
    import bor_pkg::*;
#(
    parameter int COORD_BITS = BOR_COORD_BITS,
    parameter int FRAC_BITS  = BOR_FRAC_BITS
);
    logic                    valid;
    logic                    ready;
    logic [FRAC_BITS:0]      ratio;
    logic [2*COORD_BITS-1:0] overlap_area;
    logic                    zero_denominator;

    modport source (
        output valid, ratio, overlap_area, zero_denominator,
        input  ready
    );

    modport sink (
        input  valid, ratio, overlap_area, zero_denominator,
        output ready
    );
endinterface : bor_out_if

[design/box_overlap_ratio.sv]
// ----------------------------------------------------------------------------
// box_overlap_ratio: pipelined intersection-over-union of two boxes
// Computes the overlap area of two axis-aligned boxes and its ratio to the
// union (mode 0) or to the area of box A (mode 1) as unsigned fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per box pair: mode, then x, y, width and height of
//   box A and of box B. o_out returns one beat per input beat, in order, with
//   the truncated ratio (1 << FRAC_BITS means 1.0), the overlap area and a
//   flag that is set when the selected denominator is zero (ratio then 0).
//   The pipeline has one stage for the edge overlap, one for the three area
//   multipliers, one for the denominator, and FRAC_BITS + 1 stages of
//   restoring division, one quotient bit per stage. A new beat is taken in
//   every cycle unless a stall on o_out finds every stage full.
//   Each stage holds a valid bit and loads when it is empty or when the
//   stage after it moves, so a stall on o_out only holds back the stages
//   that are full; bubbles close up and i_in stays ready while any stage
//   ahead of the stalled output is empty. Nothing is dropped or repeated.
//   The synchronous reset i_rst_n empties the pipeline; the block keeps no
//   other state.
// ----------------------------------------------------------------------------
module box_overlap_ratio
    import bor_pkg::*;
#(
    parameter int COORD_BITS = BOR_COORD_BITS,
    parameter int FRAC_BITS  = BOR_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bor_in_if.sink    i_in,
    bor_out_if.source o_out
);

    // Pipeline geometry.
    localparam int NS = FRAC_BITS + 4;       // total register stages
    localparam int AW = 2 * COORD_BITS;      // area width
    localparam int DW = AW + 1;              // denominator width (union)
    localparam int QW = FRAC_BITS + 1;       // quotient width
    localparam int DS = 3;                   // index of first divider stage

    // Overlap length of two intervals given by start and length; zero when
    // they are disjoint or only touch. The result never exceeds a length.
    function automatic logic [COORD_BITS-1:0] f_overlap(
        input logic [COORD_BITS-1:0] lo1,
        input logic [COORD_BITS-1:0] len1,
        input logic [COORD_BITS-1:0] lo2,
        input logic [COORD_BITS-1:0] len2
    );
        logic [COORD_BITS:0] hi1;
        logic [COORD_BITS:0] hi2;
        logic [COORD_BITS:0] hi;
        logic [COORD_BITS:0] lo;
        logic [COORD_BITS:0] diff;
        hi1  = {1'b0, lo1} + {1'b0, len1};
        hi2  = {1'b0, lo2} + {1'b0, len2};
        hi   = (hi1 < hi2) ? hi1 : hi2;
        lo   = (lo1 > lo2) ? {1'b0, lo1} : {1'b0, lo2};
        diff = hi - lo;
        return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
    endfunction

    // Stage valid bits and the load enables that ripple back from the output.
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;

    assign w_rdy[NS-1] = !r_v[NS-1] || o_out.ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: overlap extent in x and y, box sizes passed on.
    logic [COORD_BITS-1:0] r_ow, r_oh, r_aw, r_ah, r_bw, r_bh;
    logic                  r_mode0;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ow    <= f_overlap(i_in.a_x, i_in.a_w, i_in.b_x, i_in.b_w);
            r_oh    <= f_overlap(i_in.a_y, i_in.a_h, i_in.b_y, i_in.b_h);
            r_aw    <= i_in.a_w;
            r_ah    <= i_in.a_h;
            r_bw    <= i_in.b_w;
            r_bh    <= i_in.b_h;
            r_mode0 <= i_in.mode;
        end
    end

    // Stage 1: the overlap area and the two box areas.
    logic [AW-1:0] r_inter1, r_area_a1, r_area_b1;
    logic          r_mode1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_inter1  <= AW'(r_ow) * AW'(r_oh);
            r_area_a1 <= AW'(r_aw) * AW'(r_ah);
            r_area_b1 <= AW'(r_bw) * AW'(r_bh);
            r_mode1   <= r_mode0;
        end
    end

    // Stage 2: select the denominator and detect a zero one.
    logic [DW-1:0] n_den;
    logic [DW-1:0] r_den2;
    logic [AW-1:0] r_inter2;
    logic          r_zero2;

    assign n_den = r_mode1 ? DW'(r_area_a1)
                           : DW'(r_area_a1) + DW'(r_area_b1) - DW'(r_inter1);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_den2   <= n_den;
            r_inter2 <= r_inter1;
            r_zero2  <= (n_den == '0);
        end
    end

    // Restoring division, one quotient bit per stage. The first stage gives
    // the integer bit (overlap equals denominator), the rest the fraction.
    logic [DW-1:0] r_rem   [QW];
    logic [DW-1:0] r_den   [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [AW-1:0] r_inter [QW];
    logic [QW-1:0] r_zero;

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DW:0]   w_cur;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_qprev;
        logic [AW-1:0] w_inter;
        logic          w_zero;
        logic          w_ge;
        logic [DW:0]   w_diff;

        if (j == 0) begin : g_first
            assign w_cur   = {2'b00, r_inter2};
            assign w_den   = r_den2;
            assign w_qprev = '0;
            assign w_inter = r_inter2;
            assign w_zero  = r_zero2;
        end else begin : g_next
            assign w_cur   = {r_rem[j-1], 1'b0};
            assign w_den   = r_den[j-1];
            assign w_qprev = r_quo[j-1];
            assign w_inter = r_inter[j-1];
            assign w_zero  = r_zero[j-1];
        end

        assign w_ge   = (w_cur >= {1'b0, w_den});
        assign w_diff = w_cur - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (w_rdy[DS+j]) begin
                r_rem[j]   <= w_ge ? w_diff[DW-1:0] : w_cur[DW-1:0];
                r_den[j]   <= w_den;
                r_quo[j]   <= {w_qprev[QW-2:0], w_ge};
                r_inter[j] <= w_inter;
                r_zero[j]  <= w_zero;
            end
        end
    end

    // The last divider stage is the output register.
    assign o_out.valid            = r_v[NS-1];
    assign o_out.ratio            = r_zero[QW-1] ? '0 : r_quo[QW-1];
    assign o_out.overlap_area     = r_inter[QW-1];
    assign o_out.zero_denominator = r_zero[QW-1];

    // A zero denominator can only come with an empty overlap.
    a_zero_no_overlap : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_denominator) |-> (o_out.overlap_area == '0)
    ) else $error("zero denominator with nonzero overlap area");

    // The ratio never exceeds 1.0.
    a_ratio_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.ratio <= (QW'(1) << FRAC_BITS))
    ) else $error("ratio above 1.0");

    // A full ratio of 1.0 needs a nonempty overlap.
    a_full_ratio : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ratio[FRAC_BITS]) |-> (o_out.overlap_area != '0)
    ) else $error("ratio 1.0 with empty overlap");

    // With the output stage empty, every stage may load, so input is taken.
    a_ready_when_drained : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> i_in.ready
    ) else $error("input stalled while output stage is empty");

    // A stage that holds a beat and cannot move keeps its valid bit.
    a_hold_stalled : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v[DS] && !w_rdy[DS]) |=> r_v[DS]
    ) else $error("stalled divider beat lost");

endmodule : box_overlap_ratio
